// File: src/utf8_pc_pkg.sv
// ----------------------------------------------------------------------------
// utf8_pc_pkg
// Types and constants shared by the UTF-8 payload checker.
// ----------------------------------------------------------------------------
package utf8_pc_pkg;

  localparam int CountWidth = 17;
  localparam int CapWidth   = 16;
  localparam int CpWidth    = 21;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [1:0] VERDICT_OK        = 2'd0;
  localparam logic [1:0] VERDICT_EMPTY     = 2'd1;
  localparam logic [1:0] VERDICT_TOO_LARGE = 2'd2;
  localparam logic [1:0] VERDICT_BAD_TYPE  = 2'd3;

  localparam logic [CapWidth-1:0] CAP_RESET = 16'd61440;

  localparam logic [CpWidth-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [CpWidth-1:0] SURR_LOW     = 21'h00D800;
  localparam logic [CpWidth-1:0] SURR_HIGH    = 21'h00DFFF;
  localparam logic [CpWidth-1:0] LOWEST_TWO   = 21'h000080;
  localparam logic [CpWidth-1:0] LOWEST_THREE = 21'h000800;
  localparam logic [CpWidth-1:0] LOWEST_FOUR  = 21'h010000;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]            verdict;
    logic [CountWidth-1:0] byte_count;
  } rsp_t;

  typedef struct packed {
    logic [CountWidth-1:0] count;
    logic [1:0]            pending;
    logic [1:0]            seq_len;
    logic [CpWidth-1:0]    partial;
    logic                  malformed;
  } state_t;

  function automatic logic [CpWidth-1:0] lowest_value(input logic [1:0] seq_len);
    logic [CpWidth-1:0] v;
    unique case (seq_len)
      2'd1:    v = LOWEST_TWO;
      2'd2:    v = LOWEST_THREE;
      2'd3:    v = LOWEST_FOUR;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: src/utf8_pc_tracker.sv
// ----------------------------------------------------------------------------
// utf8_pc_tracker
// Holds the per-payload decoding state and works out the verdict.
// ----------------------------------------------------------------------------
module utf8_pc_tracker
  import utf8_pc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                enable,
  input  req_t                item,
  input  logic [CapWidth-1:0] max_length,
  output rsp_t                result,
  output state_t              state
);

  state_t state_next;
  logic [CountWidth-1:0] cap_ext;
  logic [CpWidth-1:0]    cp;
  logic [7:0]            b;

  assign cap_ext = {1'b0, max_length};
  assign b       = item.data_byte;
  assign cp      = {state.partial[CpWidth-7:0], b[5:0]};

  always_comb begin
    state_next = state;
    if (item.command == CMD_END) begin
      state_next = '0;
    end else begin
      if (state.count <= cap_ext) begin
        state_next.count = state.count + 1'b1;
      end
      if (state.pending != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          state_next.malformed = 1'b1;
          state_next.pending   = 2'd0;
        end else begin
          state_next.partial = cp;
          state_next.pending = state.pending - 1'b1;
          if (state.pending == 2'd1) begin
            if (cp < lowest_value(state.seq_len) || cp > CP_MAX ||
                (cp >= SURR_LOW && cp <= SURR_HIGH)) begin
              state_next.malformed = 1'b1;
            end
          end
        end
      end else begin
        priority if (b == 8'h00) begin
          state_next.malformed = 1'b1;
        end else if (b[7] == 1'b0) begin
          state_next.malformed = state.malformed;
        end else if (b[7:5] == 3'b110) begin
          state_next.seq_len = 2'd1;
          state_next.pending = 2'd1;
          state_next.partial = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
          state_next.seq_len = 2'd2;
          state_next.pending = 2'd2;
          state_next.partial = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
          state_next.seq_len = 2'd3;
          state_next.pending = 2'd3;
          state_next.partial = {18'd0, b[2:0]};
        end else begin
          state_next.malformed = 1'b1;
        end
      end
    end
  end

  always_comb begin
    result.byte_count = state.count;
    priority if (state.count > cap_ext) begin
      result.verdict = VERDICT_TOO_LARGE;
    end else if (state.count == '0) begin
      result.verdict = VERDICT_EMPTY;
    end else if (state.malformed || state.pending != 2'd0) begin
      result.verdict = VERDICT_BAD_TYPE;
    end else begin
      result.verdict = VERDICT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (enable) begin
      state <= state_next;
    end
  end

endmodule

// File: src/utf8_payload_checker.sv
// ----------------------------------------------------------------------------
// utf8_payload_checker
// Streaming UTF-8 well-formedness and length check, one verdict per payload.
// ----------------------------------------------------------------------------
// A payload is sent as requests on the req channel, one byte per request,
// followed by an end-of-payload request. Each end request yields one response
// on the rsp channel with the verdict and the saturated byte count; byte
// requests yield nothing. Both channels use valid and stall.
// The block takes one request per cycle while req_stall is low. A request
// waits in the input register, where the tracker state is updated as it
// advances; the verdict of an end request is registered into the response
// register as the request leaves the input register.
// When the receiver stalls, the response is held; a further end request then
// waits in the input register and req_stall rises, while byte requests keep
// flowing. The cap is written through the cfg channel, which is always ready
// and must only be used while the block is idle.
// Reset clears all payload state, empties both registers and sets the cap
// to 61440.
// ----------------------------------------------------------------------------
module utf8_payload_checker
  import utf8_pc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  req_t                req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output rsp_t                rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CapWidth-1:0] cfg_data
);

  logic                hold_valid;
  req_t                hold;
  logic                advance;
  logic                rsp_load;
  logic [CapWidth-1:0] max_length;
  rsp_t                result;
  state_t              state;

  assign cfg_ready = 1'b1;
  assign advance   = hold_valid &&
                     !(hold.command == CMD_END && rsp_valid && rsp_stall);
  assign rsp_load  = advance && hold.command == CMD_END;
  assign req_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!req_stall) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      hold <= req;
    end
  end

  utf8_pc_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .enable     (advance),
    .item       (hold),
    .max_length (max_length),
    .result     (result),
    .state      (state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= result;
    end
  end

`ifndef SYNTH
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> hold_valid && hold.command == CMD_END && rsp_valid)
    else $error("request stalled without a blocked end request");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    rsp_load |=> state.count == '0 && state.pending == 2'd0 && !state.malformed)
    else $error("payload state not cleared after a verdict");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.verdict == VERDICT_EMPTY |-> rsp.byte_count == '0)
    else $error("empty verdict with a nonzero byte count");
`endif

endmodule
